// ===== rtl/core/hit_coincidence_tally_defines.svh =====
// Assertion macros shared by the hit coincidence tally RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef HIT_COINCIDENCE_TALLY_DEFINES_SVH
`define HIT_COINCIDENCE_TALLY_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HCT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HCT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/hct_pkg.sv =====
// Shared types, constants and helper functions for the hit coincidence tally.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
package hct_pkg;

  localparam int TYPE_SLOTS_DEF = 6;

  localparam int EV_W    = 32;
  localparam int TRK_W   = 20;
  localparam int VOL_W   = 8;
  localparam int DEP_W   = 24;
  localparam int CODE_W  = 32;
  localparam int CNT_W   = 32;
  localparam int SUM_W   = 48;
  localparam int SLOTO_W = 3;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 296;

  localparam int APB_AW = 5;
  localparam int APB_DW = 32;

  localparam logic [VOL_W-1:0]  FIRST_VOL_RST   = 8'd0;
  localparam logic [VOL_W-1:0]  MIDDLE_VOL_RST  = 8'd6;
  localparam logic [VOL_W-1:0]  LAST_VOL_RST    = 8'd15;
  localparam logic [CODE_W-1:0] TRACKED_CODE_RST = 32'd2212;
  localparam logic [TRK_W-1:0]  PRIMARY_TRK_RST  = 20'd1;

  typedef enum logic [2:0] {
    REG_FIRST_VOL   = 3'd0,
    REG_MIDDLE_VOL  = 3'd1,
    REG_LAST_VOL    = 3'd2,
    REG_TRACKED     = 3'd3,
    REG_PRIMARY_TRK = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [VOL_W-1:0]  first_volume;
    logic [VOL_W-1:0]  middle_volume;
    logic [VOL_W-1:0]  last_volume;
    logic [CODE_W-1:0] tracked_code;
    logic [TRK_W-1:0]  primary_track;
  } cfg_t;

  typedef struct packed {
    logic [EV_W-1:0]   event_number;
    logic [TRK_W-1:0]  track_number;
    logic [VOL_W-1:0]  volume_number;
    logic [DEP_W-1:0]  deposit_ev;
    logic [CODE_W-1:0] particle_code;
  } hit_t;

  typedef struct packed {
    logic [CNT_W-1:0] all_fired;
    logic [CNT_W-1:0] true_primary;
    logic [CNT_W-1:0] lost_primary;
    logic [CNT_W-1:0] no_middle;
  } ctr_t;

  function automatic logic [CNT_W-1:0] sat_inc32(input logic [CNT_W-1:0] v);
    sat_inc32 = (v == '1) ? v : v + CNT_W'(1);
  endfunction

endpackage

// ===== rtl/core/hct_cfg_regs.sv =====
// APB-style configuration register file for the hit coincidence tally.
// Depends on hct_pkg for the register map and the configuration struct.
`timescale 1ns / 1ps
module hct_cfg_regs
  import hct_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_FIRST_VOL:   cfg_nxt.first_volume  = pwdata[VOL_W-1:0];
        REG_MIDDLE_VOL:  cfg_nxt.middle_volume = pwdata[VOL_W-1:0];
        REG_LAST_VOL:    cfg_nxt.last_volume   = pwdata[VOL_W-1:0];
        REG_TRACKED:     cfg_nxt.tracked_code  = pwdata[CODE_W-1:0];
        REG_PRIMARY_TRK: cfg_nxt.primary_track = pwdata[TRK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FIRST_VOL:   prdata = {{(APB_DW-VOL_W){1'b0}}, cfg_r.first_volume};
      REG_MIDDLE_VOL:  prdata = {{(APB_DW-VOL_W){1'b0}}, cfg_r.middle_volume};
      REG_LAST_VOL:    prdata = {{(APB_DW-VOL_W){1'b0}}, cfg_r.last_volume};
      REG_TRACKED:     prdata = cfg_r.tracked_code;
      REG_PRIMARY_TRK: prdata = {{(APB_DW-TRK_W){1'b0}}, cfg_r.primary_track};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_volume  <= FIRST_VOL_RST;
      cfg_r.middle_volume <= MIDDLE_VOL_RST;
      cfg_r.last_volume   <= LAST_VOL_RST;
      cfg_r.tracked_code  <= TRACKED_CODE_RST;
      cfg_r.primary_track <= PRIMARY_TRK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/core/hct_event_ctr.sv =====
// Per-event volume and primary flags with the four saturating event counters.
// Depends on hct_pkg for the counter struct and the saturating increment.
`timescale 1ns / 1ps
module hct_event_ctr
  import hct_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  logic [EV_W-1:0]  event_number,
  input  logic [2:0]       vol_hit,
  input  logic             prim,
  output ctr_t             ctr_nxt
);

  localparam logic [2:0] ALL_FIRED  = 3'b111;
  localparam logic [2:0] FIRST_LAST = 3'b101;
  localparam logic [2:0] DOWNSTREAM = 3'b110;

  logic [EV_W-1:0] cur_ev_r;
  logic [EV_W-1:0] cur_ev_nxt;
  logic [2:0]      fired_r;
  logic [2:0]      fired_nxt;
  logic [2:0]      seen_r;
  logic [2:0]      seen_nxt;
  ctr_t            ctr_r;
  logic            close;
  logic            all;

  assign close = event_number > cur_ev_r;
  assign all   = fired_r == ALL_FIRED;

  always_comb begin
    cur_ev_nxt = cur_ev_r;
    fired_nxt  = fired_r;
    seen_nxt   = seen_r;
    ctr_nxt    = ctr_r;
    if (fire) begin
      if (close) begin
        cur_ev_nxt = event_number;
        fired_nxt  = '0;
        seen_nxt   = '0;
        if (all) begin
          ctr_nxt.all_fired = sat_inc32(ctr_r.all_fired);
        end
        if (seen_r == ALL_FIRED) begin
          ctr_nxt.true_primary = sat_inc32(ctr_r.true_primary);
        end
        if (all && ((seen_r & DOWNSTREAM) == '0)) begin
          ctr_nxt.lost_primary = sat_inc32(ctr_r.lost_primary);
        end
        if (fired_r == FIRST_LAST) begin
          ctr_nxt.no_middle = sat_inc32(ctr_r.no_middle);
        end
      end
      fired_nxt = fired_nxt | vol_hit;
      seen_nxt  = seen_nxt | (vol_hit & {3{prim}});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_ev_r <= '0;
      fired_r  <= '0;
      seen_r   <= '0;
      ctr_r    <= '0;
    end else begin
      cur_ev_r <= cur_ev_nxt;
      fired_r  <= fired_nxt;
      seen_r   <= seen_nxt;
      ctr_r    <= ctr_nxt;
    end
  end

endmodule

// ===== rtl/core/hct_type_table.sv =====
// Particle code table with per-slot deposit sums and hit counts.
// Depends on hct_pkg for field widths and the saturating increment.
`timescale 1ns / 1ps
module hct_type_table
  import hct_pkg::*;
#(
  parameter int TYPE_SLOTS = TYPE_SLOTS_DEF,
  parameter int SLOT_W     = $clog2(TYPE_SLOTS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [CODE_W-1:0] code,
  input  logic [DEP_W-1:0]  deposit,
  input  logic              in_mid,
  input  logic              in_last,
  output logic [SLOT_W-1:0] slot,
  output logic [SUM_W-1:0]  mid_sum,
  output logic [CNT_W-1:0]  mid_hits,
  output logic [SUM_W-1:0]  last_sum,
  output logic [CNT_W-1:0]  last_hits
);

  localparam int IDX_W = (TYPE_SLOTS > 1) ? $clog2(TYPE_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(TYPE_SLOTS);

  logic [CODE_W-1:0] codes_r     [TYPE_SLOTS];
  logic [SUM_W-1:0]  mid_sum_r   [TYPE_SLOTS];
  logic [CNT_W-1:0]  mid_hits_r  [TYPE_SLOTS];
  logic [SUM_W-1:0]  last_sum_r  [TYPE_SLOTS];
  logic [CNT_W-1:0]  last_hits_r [TYPE_SLOTS];

  logic [SLOT_W-1:0] hit_sel;
  logic [SLOT_W-1:0] free_sel;
  logic              has_hit;
  logic              has_free;
  logic              valid;
  logic [IDX_W-1:0]  idx;
  logic              wr;

  function automatic logic [SUM_W-1:0] sat_add48(input logic [SUM_W-1:0] a,
                                                 input logic [DEP_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {{(SUM_W+1-DEP_W){1'b0}}, b};
    sat_add48 = s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

  always_comb begin
    hit_sel  = NO_SLOT;
    free_sel = NO_SLOT;
    has_hit  = 1'b0;
    has_free = 1'b0;
    for (int i = TYPE_SLOTS - 1; i >= 0; i--) begin
      if (codes_r[i] == code) begin
        hit_sel = SLOT_W'(i);
        has_hit = 1'b1;
      end
      if (codes_r[i] == '0) begin
        free_sel = SLOT_W'(i);
        has_free = 1'b1;
      end
    end
  end

  assign valid = (deposit != '0) && (has_hit || has_free);
  assign slot  = valid ? (has_hit ? hit_sel : free_sel) : NO_SLOT;
  assign idx   = slot[IDX_W-1:0];
  assign wr    = fire && valid;

  always_comb begin
    mid_sum   = '0;
    mid_hits  = '0;
    last_sum  = '0;
    last_hits = '0;
    if (valid) begin
      mid_sum   = in_mid  ? sat_add48(mid_sum_r[idx], deposit)  : mid_sum_r[idx];
      mid_hits  = in_mid  ? sat_inc32(mid_hits_r[idx])          : mid_hits_r[idx];
      last_sum  = in_last ? sat_add48(last_sum_r[idx], deposit) : last_sum_r[idx];
      last_hits = in_last ? sat_inc32(last_hits_r[idx])         : last_hits_r[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TYPE_SLOTS; i++) begin
        codes_r[i]     <= '0;
        mid_sum_r[i]   <= '0;
        mid_hits_r[i]  <= '0;
        last_sum_r[i]  <= '0;
        last_hits_r[i] <= '0;
      end
    end else if (wr) begin
      codes_r[idx]     <= code;
      mid_sum_r[idx]   <= mid_sum;
      mid_hits_r[idx]  <= mid_hits;
      last_sum_r[idx]  <= last_sum;
      last_hits_r[idx] <= last_hits;
    end
  end

endmodule

// ===== rtl/core/hit_coincidence_tally.sv =====
// Hits pass the input register, then the result register: one hit per cycle
// unless out_tready stalls. The code table updates in the cycle it is read.
// Stalls: the input register refills in the same cycle the result register drains.
// Reset (synchronous, rst_n low): configuration returns to its defaults, and the
// event flags, counters, code table, sums and hit counts all clear at once.
`timescale 1ns / 1ps
module hit_coincidence_tally
  import hct_pkg::*;
#(
  parameter int TYPE_SLOTS = TYPE_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // event_number, track_number, volume_number, deposit_ev, particle_code, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // all_fired_count, true_primary_count, lost_primary_count, no_middle_count,
  // slot_used, middle_sum, middle_hits, last_sum, last_hits, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_AW-1:0]     cfg_paddr,
  input  logic [APB_DW-1:0]     cfg_pwdata,
  output logic [APB_DW-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

  `include "hit_coincidence_tally_defines.svh"

  localparam int SLOT_W = $clog2(TYPE_SLOTS + 1);
  localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(TYPE_SLOTS);

  cfg_t              cfg;
  hit_t              hit_r;
  logic              in_valid_r;
  logic              in_valid_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              adv;
  logic              fire;
  logic              in_acc;
  logic              prim;
  logic [2:0]        vol_hit;
  ctr_t              ctr_nxt;
  ctr_t              ctr_out_r;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W+2:0] slot_ext;
  logic [SUM_W-1:0]  mid_sum;
  logic [CNT_W-1:0]  mid_hits;
  logic [SUM_W-1:0]  last_sum;
  logic [CNT_W-1:0]  last_hits;
  logic [SUM_W-1:0]  mid_sum_r;
  logic [CNT_W-1:0]  mid_hits_r;
  logic [SUM_W-1:0]  last_sum_r;
  logic [CNT_W-1:0]  last_hits_r;

  hct_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign adv       = !out_valid_r || out_tready;
  assign fire      = in_valid_r && adv;
  assign in_tready = !in_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  assign prim = (hit_r.particle_code == cfg.tracked_code) &&
                (hit_r.track_number == cfg.primary_track);
  assign vol_hit = {hit_r.volume_number == cfg.last_volume,
                    hit_r.volume_number == cfg.middle_volume,
                    hit_r.volume_number == cfg.first_volume};

  hct_event_ctr u_evt (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .event_number (hit_r.event_number),
    .vol_hit      (vol_hit),
    .prim         (prim),
    .ctr_nxt      (ctr_nxt)
  );

  hct_type_table #(
    .TYPE_SLOTS (TYPE_SLOTS),
    .SLOT_W     (SLOT_W)
  ) u_tbl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .code      (hit_r.particle_code),
    .deposit   (hit_r.deposit_ev),
    .in_mid    (vol_hit[1]),
    .in_last   (vol_hit[2]),
    .slot      (slot),
    .mid_sum   (mid_sum),
    .mid_hits  (mid_hits),
    .last_sum  (last_sum),
    .last_hits (last_hits)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_acc) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      hit_r.event_number  <= in_tdata[31:0];
      hit_r.track_number  <= in_tdata[51:32];
      hit_r.volume_number <= in_tdata[59:52];
      hit_r.deposit_ev    <= in_tdata[83:60];
      hit_r.particle_code <= in_tdata[115:84];
    end
    if (fire) begin
      ctr_out_r   <= ctr_nxt;
      slot_r      <= slot;
      mid_sum_r   <= mid_sum;
      mid_hits_r  <= mid_hits;
      last_sum_r  <= last_sum;
      last_hits_r <= last_hits;
    end
  end

  assign slot_ext   = {3'b000, slot_r};
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, last_hits_r, last_sum_r, mid_hits_r, mid_sum_r,
                       slot_ext[2:0], ctr_out_r.no_middle, ctr_out_r.lost_primary,
                       ctr_out_r.true_primary, ctr_out_r.all_fired};

  `HCT_ASSERT_NXT(a_fire_loads_out, fire, out_valid_r,
    "A transaction that left the input register did not reach the result register.")
  `HCT_ASSERT_NXT(a_zero_dep_no_slot, fire && (hit_r.deposit_ev == '0), slot_r == NO_SLOT,
    "A zero deposit was assigned a table slot.")
  `HCT_ASSERT_IMP(a_no_slot_zero, out_valid_r && (slot_r == NO_SLOT),
    (mid_sum_r == '0) && (mid_hits_r == '0) && (last_sum_r == '0) && (last_hits_r == '0),
    "A result without a slot carries nonzero sums or hit counts.")

endmodule
